>>> rtl/ewfr_pkg.sv
`default_nettype none
package ewfr_pkg;

  localparam logic [15:0] WORD_IDLE_HI     = 16'hFFFF;
  localparam logic [15:0] WORD_IDLE_HI_SUB = 16'h0EE1;
  localparam logic [15:0] WORD_IDLE_LO     = 16'h0000;
  localparam logic [15:0] WORD_IDLE_LO_SUB = 16'h0EE0;
  localparam logic [15:0] WORD_STX         = 16'h0ED0;
  localparam logic [15:0] WORD_ESC         = 16'h0ED2;
  localparam logic [15:0] WORD_XOR         = 16'hA0A0;

  localparam logic [15:0] MAX_FRAME_BYTES_RESET = 16'd2048;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_START  = 3'd1;
  localparam logic [2:0] EV_SIZE   = 3'd2;
  localparam logic [2:0] EV_REJECT = 3'd3;
  localparam logic [2:0] EV_DATA   = 3'd4;
  localparam logic [2:0] EV_LAST   = 3'd5;
  localparam logic [2:0] EV_ABORT  = 3'd6;

  typedef enum logic [4:0] {
    PH_WAIT     = 5'b00001,
    PH_SIZE     = 5'b00010,
    PH_SIZE_ESC = 5'b00100,
    PH_DATA     = 5'b01000,
    PH_DATA_ESC = 5'b10000
  } phase_t;

  // Swap idle words with their substitute codes, both directions.
  function automatic logic [15:0] swap_idle(input logic [15:0] w);
    logic [15:0] r;
    begin
      r = w;
      if (w == WORD_IDLE_HI) r = WORD_IDLE_HI_SUB;
      else if (w == WORD_IDLE_LO) r = WORD_IDLE_LO_SUB;
      else if (w == WORD_IDLE_HI_SUB) r = WORD_IDLE_HI;
      else if (w == WORD_IDLE_LO_SUB) r = WORD_IDLE_LO;
      return r;
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/escaped_word_frame_receiver_top.sv
// Escaped word frame receiver.
// Input channel (in_valid / in_ready / rx_word) carries one 16-bit word from
// the serial link per handshake. Output channel (out_valid / out_ready) gives
// one result per accepted word: event_res, byte_count, byte_high, byte_low and
// frame_length. Idle words and escape prefixes still give a result, with
// event_res set to EV_NONE.
// An accepted word goes into the input register, is decoded, and is written to
// the result register. Throughput: one word per cycle while the output is not
// stalled, set by the single decode stage between the two registers.
// The configuration register max_frame_bytes is written through cfg_write_en
// and cfg_write_data; the user must change it only while the block is idle.
// The block does not enforce this. Reset (rst, synchronous) empties both
// registers, returns the receiver to waiting for a start word, clears the
// byte counter and sets max_frame_bytes to 2048. When the receiver stalls
// (out_ready low) the result holds; the input register still takes one more
// word, and in_ready then drops until the result is taken.
`default_nettype none
module escaped_word_frame_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic [15:0] cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] rx_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       event_res,
  output logic [1:0]       byte_count,
  output logic [7:0]       byte_high,
  output logic [7:0]       byte_low,
  output logic [15:0]      frame_length
);
  import ewfr_pkg::*;

  // Configuration.
  logic [15:0] max_frame_bytes;

  // Input register.
  logic        word_valid;
  logic [15:0] word;

  // Receiver state.
  phase_t      phase, phase_next;
  logic [15:0] bytes_left, bytes_left_next;

  // Decoded result.
  logic [2:0]  event_next;
  logic [1:0]  byte_count_next;
  logic [7:0]  byte_high_next;
  logic [7:0]  byte_low_next;
  logic [15:0] frame_length_next;

  logic        advance;
  logic        in_escape;
  logic [15:0] unesc_word;
  logic [15:0] decoded;
  logic        word_is_idle;

  // Advance the input word whenever the result register is empty or drains.
  assign advance  = word_valid && (!out_valid || out_ready);
  assign in_ready = !word_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= MAX_FRAME_BYTES_RESET;
    end else if (cfg_write_en) begin
      max_frame_bytes <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_ready) begin
      word_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= rx_word;
    end
  end

  // One XOR and one substitution shared by the size and payload paths.
  assign in_escape    = (phase == PH_SIZE_ESC) || (phase == PH_DATA_ESC);
  assign unesc_word   = in_escape ? (word ^ WORD_XOR) : word;
  assign decoded      = swap_idle(unesc_word);
  assign word_is_idle = (word == WORD_IDLE_HI) || (word == WORD_IDLE_LO);

  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    event_next        = EV_NONE;
    byte_count_next   = 2'd0;
    byte_high_next    = 8'd0;
    byte_low_next     = 8'd0;
    frame_length_next = 16'd0;

    case (phase)
      PH_SIZE: begin
        if (word == WORD_ESC) begin
          phase_next = PH_SIZE_ESC;
        end else if (word == WORD_IDLE_HI) begin
          phase_next = PH_SIZE;
        end else if ((word == WORD_IDLE_LO) || (word == WORD_IDLE_HI_SUB) ||
                     (word == WORD_IDLE_LO_SUB) || (word > max_frame_bytes)) begin
          phase_next      = PH_WAIT;
          bytes_left_next = 16'd0;
          event_next      = EV_REJECT;
        end else begin
          phase_next        = PH_DATA;
          bytes_left_next   = decoded;
          event_next        = EV_SIZE;
          frame_length_next = decoded;
        end
      end
      PH_SIZE_ESC: begin
        // Compare the raw word against the limit, before the XOR.
        if (word == WORD_IDLE_HI) begin
          phase_next = PH_SIZE_ESC;
        end else if ((word != WORD_IDLE_LO) && (word <= max_frame_bytes)) begin
          phase_next        = PH_DATA;
          bytes_left_next   = decoded;
          event_next        = EV_SIZE;
          frame_length_next = decoded;
        end else begin
          phase_next      = PH_WAIT;
          bytes_left_next = 16'd0;
          event_next      = EV_REJECT;
        end
      end
      PH_DATA, PH_DATA_ESC: begin
        if ((phase == PH_DATA) && (word == WORD_STX)) begin
          phase_next      = PH_SIZE;
          bytes_left_next = 16'd0;
          event_next      = EV_ABORT;
        end else if ((phase == PH_DATA) && (word == WORD_ESC)) begin
          phase_next = PH_DATA_ESC;
        end else if (!word_is_idle) begin
          byte_high_next = decoded[15:8];
          if (bytes_left > 16'd2) begin
            event_next      = EV_DATA;
            byte_count_next = 2'd2;
            byte_low_next   = decoded[7:0];
            bytes_left_next = bytes_left - 16'd2;
            phase_next      = PH_DATA;
          end else begin
            event_next      = EV_LAST;
            bytes_left_next = 16'd0;
            phase_next      = PH_WAIT;
            if (bytes_left == 16'd2) begin
              byte_count_next = 2'd2;
              byte_low_next   = decoded[7:0];
            end else begin
              byte_count_next = 2'd1;
            end
          end
        end
      end
      default: begin
        if (word == WORD_STX) begin
          phase_next = PH_SIZE;
          event_next = EV_START;
        end else begin
          phase_next = PH_WAIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_WAIT;
      bytes_left <= 16'd0;
    end else if (advance) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_res    <= event_next;
      byte_count   <= byte_count_next;
      byte_high    <= byte_high_next;
      byte_low     <= byte_low_next;
      frame_length <= frame_length_next;
    end
  end

  // Outside the payload phases no bytes remain outstanding.
  a_idle_no_bytes: assert property (@(posedge clk) disable iff (rst)
    ((phase == PH_WAIT) || (phase == PH_SIZE) || (phase == PH_SIZE_ESC))
      |-> (bytes_left == 16'd0))
    else $error("bytes_left nonzero outside payload phases");

  // A last payload word returns the receiver to waiting for a start word.
  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (advance && (event_next == EV_LAST)) |=> (phase == PH_WAIT))
    else $error("frame did not end after last payload word");

  // frame_length is only nonzero with a size accepted event.
  a_length_only_on_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_res != EV_SIZE)) |-> (frame_length == 16'd0))
    else $error("frame_length set without size event");

  // A full payload word always carries two bytes.
  a_data_two_bytes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_res == EV_DATA)) |-> (byte_count == 2'd2))
    else $error("payload word without two bytes");

endmodule
`default_nettype wire

>>> verif/escaped_word_frame_receiver_top_tb.sv
`timescale 1ns / 100ps

module escaped_word_frame_receiver_top_tb;
  import ewfr_pkg::*;

  // One decoded result, in the order the block reports its fields.
  typedef struct packed {
    logic [2:0]  event_code;
    logic [1:0]  count;
    logic [7:0]  high;
    logic [7:0]  low;
    logic [15:0] length;
  } rx_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [15:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] rx_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_res;
  logic [1:0]  byte_count;
  logic [7:0]  byte_high;
  logic [7:0]  byte_low;
  logic [15:0] frame_length;

  // Receiver copy kept by the checker.
  phase_t      rx_state = PH_WAIT;
  logic [15:0] left_bytes = '0;
  logic [15:0] frame_max = MAX_FRAME_BYTES_RESET;

  logic [15:0] line_words[$];
  rx_result_t  pending_results[$];
  int          err_count = 0;
  int          made_words = 0;

  // Handshake flags passed from the sampling edge to the driving edge.
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit hold_req = 1'b0;
  int in_gap = 0;
  int out_wait = 0;
  int hold_left = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  escaped_word_frame_receiver_top DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_word        (rx_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .event_res      (event_res),
    .byte_count     (byte_count),
    .byte_high      (byte_high),
    .byte_low       (byte_low),
    .frame_length   (frame_length)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Receiver model
  // ---------------------------------------------------------------------

  // Trade an idle word for its substitute code and back; others pass through.
  function automatic logic [15:0] idle_swap(input logic [15:0] w);
    case (w)
      WORD_IDLE_HI:     return WORD_IDLE_HI_SUB;
      WORD_IDLE_LO:     return WORD_IDLE_LO_SUB;
      WORD_IDLE_HI_SUB: return WORD_IDLE_HI;
      WORD_IDLE_LO_SUB: return WORD_IDLE_LO;
      default:          return w;
    endcase
  endfunction

  // Decode one un-escaped payload word; the last word may carry one byte only.
  function automatic rx_result_t take_payload(input logic [15:0] w);
    rx_result_t r;
    logic [15:0] d;
    r = '0;
    d = idle_swap(w);
    r.high = d[15:8];
    if (left_bytes > 16'd2) begin
      r.event_code = EV_DATA;
      r.count = 2'd2;
      r.low = d[7:0];
      left_bytes = left_bytes - 16'd2;
      rx_state = PH_DATA;
    end else begin
      r.event_code = EV_LAST;
      if (left_bytes == 16'd2) begin
        r.count = 2'd2;
        r.low = d[7:0];
      end else begin
        r.count = 2'd1;
      end
      left_bytes = '0;
      rx_state = PH_WAIT;
    end
    return r;
  endfunction

  function automatic rx_result_t take_size(input logic [15:0] w);
    rx_result_t r;
    r = '0;
    left_bytes = idle_swap(w);
    rx_state = PH_DATA;
    r.event_code = EV_SIZE;
    r.length = left_bytes;
    return r;
  endfunction

  function automatic rx_result_t drop_size();
    rx_result_t r;
    r = '0;
    left_bytes = '0;
    rx_state = PH_WAIT;
    r.event_code = EV_REJECT;
    return r;
  endfunction

  // Advance the model by one line word and return the result it reports.
  function automatic rx_result_t decode_line_word(input logic [15:0] w);
    rx_result_t r;
    logic idle;
    r = '0;
    idle = (w == WORD_IDLE_HI) || (w == WORD_IDLE_LO);
    case (rx_state)
      PH_SIZE: begin
        if ((!idle && w != WORD_ESC && w > frame_max) || w == WORD_IDLE_HI_SUB ||
            w == WORD_IDLE_LO_SUB || w == WORD_IDLE_LO) begin
          r = drop_size();
        end else if (w == WORD_ESC) begin
          rx_state = PH_SIZE_ESC;
        end else if (!idle) begin
          r = take_size(w);
        end
      end
      PH_SIZE_ESC: begin
        // The raw word is range-checked before the XOR is undone.
        if (!idle && w <= frame_max) begin
          r = take_size(w ^ WORD_XOR);
        end else if ((!idle && w > frame_max) || w == WORD_IDLE_HI_SUB ||
                     w == WORD_IDLE_LO_SUB || w == WORD_IDLE_LO) begin
          r = drop_size();
        end
      end
      PH_DATA: begin
        if (w == WORD_STX) begin
          // Start word in mid-frame: drop the frame and expect a new size.
          left_bytes = '0;
          rx_state = PH_SIZE;
          r.event_code = EV_ABORT;
        end else if (w == WORD_ESC) begin
          rx_state = PH_DATA_ESC;
        end else if (!idle) begin
          r = take_payload(w);
        end
      end
      PH_DATA_ESC: begin
        if (!idle) r = take_payload(w ^ WORD_XOR);
      end
      default: begin
        if (w == WORD_STX) begin
          rx_state = PH_SIZE;
          r.event_code = EV_START;
        end else begin
          rx_state = PH_WAIT;
        end
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sampling at the rising edge: predict on input, check on output
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    rx_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pending_results.push_back(decode_line_word(rx_word));
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result with no word pending: event_res %0d", event_res);
          err_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("event_res", 32'(want.event_code), 32'(event_res));
          check_field("byte_count", 32'(want.count), 32'(byte_count));
          check_field("byte_high", 32'(want.high), 32'(byte_high));
          check_field("byte_low", 32'(want.low), 32'(byte_low));
          check_field("frame_length", 32'(want.length), 32'(frame_length));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Word driver: hold the word until taken, then idle for a drawn gap
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    logic        nv;
    logic [15:0] nw;
    nv = in_valid;
    nw = rx_word;
    if (!rst) begin
      if (!in_valid || in_taken) begin
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (line_words.size() > 0) begin
          nv = 1'b1;
          nw = line_words.pop_front();
          // Switch now and then into back-to-back bursts.
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, 12);
        end
      end
    end
    in_taken = 1'b0;
    in_valid <= nv;
    rx_word <= nw;
  end

  // ---------------------------------------------------------------------
  // Result taker: random wait per result, plus one long hold on request
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (!rst) begin
      if (hold_req) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_wait = out_burst ? 0 : $urandom_range(0, 12);
        out_taken = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (out_wait > 0) begin
        out_wait--;
      end else begin
        rdy = 1'b1;
      end
    end
    out_ready <= rdy;
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic send(input logic [15:0] w);
    line_words.push_back(w);
    if (w != WORD_IDLE_HI && w != WORD_IDLE_LO) made_words++;
  endtask

  // Encode one payload value the way a transmitter would: substitute idle
  // codes, escape anything the receiver would read as control.
  task automatic send_data(input logic [15:0] d);
    logic [15:0] w;
    w = idle_swap(d);
    if ($urandom_range(0, 15) == 0) send($urandom_range(0, 1) ? WORD_IDLE_HI : WORD_IDLE_LO);
    if (w == WORD_STX || w == WORD_ESC || w == WORD_IDLE_HI || w == WORD_IDLE_LO ||
        $urandom_range(0, 9) == 0) begin
      send(WORD_ESC);
      send(w ^ WORD_XOR);
    end else begin
      send(w);
    end
  endtask

  function automatic logic [15:0] pick_data();
    case ($urandom_range(0, 11))
      0: return WORD_IDLE_HI;
      1: return WORD_IDLE_LO;
      2: return $urandom_range(0, 1) ? WORD_IDLE_HI_SUB : WORD_IDLE_LO_SUB;
      3: return $urandom_range(0, 1) ? WORD_STX : WORD_ESC;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Send a frame of len bytes; cut >= 0 stops the payload after that many
  // words. Payload follows only when the size will be accepted.
  task automatic send_frame(input logic [15:0] len, input bit esc_len, input bit with_stx,
                            input int cut);
    logic [15:0] raw;
    bit ok;
    int nwords;
    if (with_stx) send(WORD_STX);
    if (esc_len) begin
      raw = idle_swap(len) ^ WORD_XOR;
      send(WORD_ESC);
      send(raw);
      ok = raw <= frame_max && raw != WORD_IDLE_HI && raw != WORD_IDLE_LO;
    end else begin
      send(len);
      ok = len != WORD_IDLE_LO && len != WORD_IDLE_HI && len != WORD_IDLE_HI_SUB &&
           len != WORD_IDLE_LO_SUB && len != WORD_ESC && len <= frame_max;
    end
    if (ok) begin
      nwords = (len == 16'd0) ? 1 : (int'(len) + 1) / 2;
      if (cut >= 0 && cut < nwords) nwords = cut;
      repeat (nwords) send_data(pick_data());
    end
  endtask

  // Mostly well-formed frames with short payloads; the rest noise, stray
  // idle words and frames broken off by a start word.
  task automatic random_traffic(input int target);
    int stop_at;
    stop_at = made_words + target;
    while (made_words < stop_at) begin
      case ($urandom_range(0, 11))
        0: send(16'($urandom_range(0, 65535)));
        1: send($urandom_range(0, 1) ? WORD_IDLE_HI : WORD_IDLE_LO);
        2: begin
          send_frame(16'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0, 1'b1,
                     $urandom_range(0, 3));
          send(WORD_STX);
          send_frame(16'($urandom_range(1, 24)), $urandom_range(0, 3) == 0, 1'b0, -1);
        end
        3: send_frame(16'($urandom_range(25, 300)), $urandom_range(0, 3) == 0, 1'b1, -1);
        default: send_frame(16'($urandom_range(1, 24)), $urandom_range(0, 3) == 0, 1'b1,
                            -1);
      endcase
    end
  endtask

  // Wait until every word is sent and every result has come back.
  task automatic drain();
    do @(negedge clk);
    while (line_words.size() != 0 || in_valid || pending_results.size() != 0);
  endtask

  // Change the maximum only with the block idle; let the pipeline settle first.
  task automatic set_frame_max(input logic [15:0] value);
    drain();
    repeat (4) @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    frame_max = value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    logic [15:0] settings[$];
    settings = '{16'd0, 16'd16, 16'hFFFF, 16'd0, 16'd2048, 16'd300, 16'd0};
    settings[3] = 16'($urandom_range(0, 65535));
    settings[6] = 16'($urandom_range(1, 4000));

    // Hold reset from the start, release it on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    rx_state = PH_WAIT;
    left_bytes = '0;
    frame_max = MAX_FRAME_BYTES_RESET;

    // Default maximum: idle and stray words while waiting, plain sizes,
    // substituted payload, escaped last byte, substitute and oversized
    // size words, idle in mid-frame, abort and restart, escaped size too big.
    send(WORD_IDLE_HI);
    send(16'h1234);
    send(WORD_STX);
    send(WORD_IDLE_HI);
    send(16'd3);
    send(WORD_IDLE_HI_SUB);
    send(WORD_ESC);
    send(WORD_STX ^ WORD_XOR);
    send(WORD_STX);
    send(WORD_IDLE_LO_SUB);
    send(WORD_STX);
    send(16'd2049);
    send(WORD_STX);
    send(16'd4);
    send(WORD_IDLE_LO);
    send(16'h1111);
    send(WORD_STX);
    send(16'd1);
    send(WORD_IDLE_LO_SUB);
    send(WORD_STX);
    send(WORD_ESC);
    send(16'h0900);

    // Widest maximum: escaped size, an escaped idle word in the payload, a size
    // that decodes to zero, a zero size word, an escaped raw zero.
    set_frame_max(16'hFFFF);
    send(WORD_STX);
    send(WORD_ESC);
    send(16'd5 ^ WORD_XOR);
    send(WORD_ESC);
    send(WORD_IDLE_HI ^ WORD_XOR);
    send(16'h1234);
    send(16'h0102);
    send(16'h0304);
    send(WORD_STX);
    send(WORD_ESC);
    send(WORD_IDLE_LO_SUB ^ WORD_XOR);
    send(16'h5555);
    send(WORD_STX);
    send(WORD_IDLE_LO);
    send(WORD_STX);
    send(WORD_ESC);
    send(WORD_IDLE_LO);

    foreach (settings[i]) begin
      set_frame_max(settings[i]);
      random_traffic(150);
      // Stall the output for a long stretch once so the input backs up.
      if (i == 1) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
